// ----- rtl/sha256_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned BLOCK_W = 512;

   localparam logic [WORD_W-1:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic start;   // load block and run the compression
      logic init;    // reload chaining value with INIT_H
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;    // chaining value updated at the end of this cycle
   } core_sts_type;

   typedef logic [7:0][WORD_W-1:0] chain_type;

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h00000000;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/sha256_stream_hasher.sv -----
// Streaming SHA-256 hasher: byte intake, padding sequencer and digest output.
// Each byte request is taken while idle; the 64th byte of a block adds a
// compression (start, 64 rounds at one round per cycle, chaining add).
// A last request runs the padding one byte per cycle, except while a full
// block compresses, with a turn step before the length; it takes one or two
// compressions in all, then 8 digest words at one per cycle when not stalled.
// Reset: chaining value to the initial hash, fill and bit counts to zero;
// the block buffer is not cleared and holds garbage until written.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha256_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_KICK = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_MARK = 3'd3;
   localparam logic [2:0] ST_ZERO = 3'd4;
   localparam logic [2:0] ST_LEN  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   localparam logic [5:0] FILL_FULL = 6'd63;
   localparam logic [5:0] FILL_LEN  = 6'd56;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         resume_ff, resume_in;
   logic [5:0]         fill_ff, fill_in;
   logic [63:0]        bits_ff, bits_in;
   logic [2:0]         idx_ff, idx_in;
   logic [BLOCK_W-1:0] buf_ff;
   logic               shift_en;
   logic [7:0]         shift_byte;

   core_ctl_type ctl;
   core_sts_type sts;
   chain_type    chain;

   sha256_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .block (buf_ff),
      .sts   (sts),
      .chain (chain)
   );

   always_comb begin
      state_in   = state_ff;
      resume_in  = resume_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      idx_in     = idx_ff;
      shift_en   = 1'b0;
      shift_byte = 8'h00;
      ctl        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  shift_en   = 1'b1;
                  shift_byte = req_data_byte;
                  fill_in    = fill_ff + 6'd1;
                  bits_in    = bits_ff + 64'd8;
               end
               if (req_has_byte && fill_ff == FILL_FULL) begin
                  state_in  = ST_KICK;
                  resume_in = req_is_last ? ST_MARK : ST_IDLE;
               end else if (req_is_last) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            shift_en   = 1'b1;
            shift_byte = 8'h80;
            fill_in    = fill_ff + 6'd1;
            state_in   = ST_ZERO;
            if (fill_ff == FILL_FULL) begin
               state_in  = ST_KICK;
               resume_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (fill_ff == FILL_LEN) begin
               state_in = ST_LEN;
            end else begin
               shift_en = 1'b1;
               fill_in  = fill_ff + 6'd1;
               if (fill_ff == FILL_FULL) begin
                  // extra block: marker landed at byte 56 to 62
                  state_in  = ST_KICK;
                  resume_in = ST_ZERO;
               end
            end
         end
         ST_LEN: begin
            // length goes out big-endian; eight shifts also clear it
            shift_en   = 1'b1;
            shift_byte = bits_ff[63:56];
            bits_in    = {bits_ff[55:0], 8'h00};
            fill_in    = fill_ff + 6'd1;
            if (fill_ff == FILL_FULL) begin
               state_in  = ST_KICK;
               resume_in = ST_OUT;
            end
         end
         ST_KICK: begin
            ctl.start = 1'b1;
            state_in  = ST_COMP;
         end
         ST_COMP: begin
            if (sts.done) begin
               state_in = resume_ff;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  ctl.init = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         resume_ff <= ST_IDLE;
         fill_ff   <= 6'd0;
         bits_ff   <= 64'd0;
         idx_ff    <= 3'd0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         fill_ff   <= fill_in;
         bits_ff   <= bits_in;
         idx_ff    <= idx_in;
      end
      if (shift_en) begin
         buf_ff <= {buf_ff[BLOCK_W-9:0], shift_byte};
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !sts.busy)
      else $error("compression started while engine busy");

   a_clear_after_digest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> (fill_ff == 6'd0 && bits_ff == 64'd0))
      else $error("counts not cleared after digest");

   a_word_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word)
         |=> (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word sequence broken");

   a_len_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (fill_ff[5:3] == 3'b111))
      else $error("length bytes outside the last eight slots");

endmodule

// ----- rtl/sha256_core.sv -----
// SHA-256 compression engine: one round per cycle plus chaining value storage.
module sha256_core (
   input  logic                           clock,
   input  logic                           reset,
   input  sha256_pkg::core_ctl_type       ctl,
   input  logic [sha256_pkg::BLOCK_W-1:0] block,
   output sha256_pkg::core_sts_type       sts,
   output sha256_pkg::chain_type          chain
);
   import sha256_pkg::*;

   localparam logic [1:0] CS_IDLE  = 2'd0;
   localparam logic [1:0] CS_ROUND = 2'd1;
   localparam logic [1:0] CS_ADD   = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic [15:0][31:0]      w_ff, w_in;
   logic [7:0][31:0]       v_ff, v_in;
   chain_type              chain_ff, chain_in;

   logic [31:0] w_next, t1, t2, ch, maj;
   logic [31:0] a, b, c, d, e, f, g, h;

   assign a = v_ff[0]; assign b = v_ff[1]; assign c = v_ff[2]; assign d = v_ff[3];
   assign e = v_ff[4]; assign f = v_ff[5]; assign g = v_ff[6]; assign h = v_ff[7];

   assign ch     = (e & f) ^ (~e & g);
   assign maj    = (a & b) ^ (a & c) ^ (b & c);
   assign t1     = h + bsig1(e) + ch + round_k(cnt_ff) + w_ff[0];
   assign t2     = bsig0(a) + maj;
   // w_ff[0] is W[t]; window slides by one word per round
   assign w_next = ssig1(w_ff[14]) + w_ff[9] + ssig0(w_ff[1]) + w_ff[0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      w_in     = w_ff;
      v_in     = v_ff;
      chain_in = chain_ff;
      case (state_ff)
         CS_IDLE: begin
            if (ctl.start) begin
               for (int i = 0; i < 16; i++) begin
                  w_in[i] = block[BLOCK_W-1-32*i -: 32];
               end
               for (int i = 0; i < 8; i++) begin
                  v_in[i] = chain_ff[i];
               end
               cnt_in   = 6'd0;
               state_in = CS_ROUND;
            end
         end
         CS_ROUND: begin
            w_in = {w_next, w_ff[15:1]};
            v_in = {g, f, e, d + t1, c, b, a, t1 + t2};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = CS_ADD;
            end
         end
         CS_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
      if (ctl.init) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = INIT_H[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         cnt_ff   <= 6'd0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= INIT_H[i];
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         chain_ff <= chain_in;
      end
      w_ff <= w_in;
      v_ff <= v_in;
   end

   assign sts.busy = (state_ff != CS_IDLE);
   assign sts.done = (state_ff == CS_ADD);
   assign chain    = chain_ff;

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (ctl.start && state_ff == CS_IDLE) |=> (state_ff == CS_ROUND && cnt_ff == 6'd0))
      else $error("compression did not begin at round 0");

   a_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_ROUND && cnt_ff == 6'd63) |=> state_ff == CS_ADD)
      else $error("final round not followed by chaining add");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> !sts.busy)
      else $error("engine still busy after done");

endmodule
